@@ rtl/tlpq_pkg.sv @@
// ----------------------------------------------------------------------------
// tlpq_pkg: shared types and constants of the two-level priority queue
// Holds the queue depth, the beat formats of both channels, the stored
// entry format, and the opcode and status codes.
// ----------------------------------------------------------------------------
package tlpq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] OP_ENQ    = 2'd0;
    localparam logic [1:0] OP_TAKE   = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] patient_id;
        logic        urgent;
        logic [2:0]  room_class;
        logic [15:0] payload_tag;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_id;
        logic        out_urgent;
        logic [2:0]  out_class;
        logic [15:0] out_payload;
        logic        queue_empty;
    } rsp_t;

    typedef struct packed {
        logic [15:0] id;
        logic        urgent;
        logic [2:0]  cls;
        logic [15:0] payload;
    } entry_t;

endpackage

@@ rtl/two_level_priority_queue_with_match.sv @@
// ----------------------------------------------------------------------------
// two_level_priority_queue_with_match: ordered queue with class match
// Keeps up to QUEUE_DEPTH entries in rank order in a one-read, one-write memory and
// serves enqueue, take-by-class and remove-by-id with a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (req_valid, req_stall, req) carries one operation per
// beat. The response channel (rsp_valid, rsp_stall, rsp) returns exactly one
// beat for every request, in request order.
// Each operation walks the entry memory one entry at a time through its one
// read port: a read state and an evaluate state for each entry examined during
// the search, and a check state and a write state for each entry moved when a
// gap is opened or closed. A full queue or an unused opcode skips the walk,
// and req_stall stays high until the block is back in its idle state.
// A finished response sits in an output register, so the next request is
// taken while the previous response still waits on rsp_stall. A second
// response waits inside the block until that register is free.
// Reset empties the queue at once by clearing the entry count; the memory
// itself is not cleared. After reset the block takes a request at once.
// ----------------------------------------------------------------------------
module two_level_priority_queue_with_match
    import tlpq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_INS_CHK,
        S_INS_WR,
        S_DEL_CHK,
        S_DEL_WR,
        S_FINISH
    } state_t;

    state_t             state_reg;
    req_t               req_reg;
    rsp_t               res_reg;
    rsp_t               rsp_reg;
    logic               rsp_valid_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   pos_reg;
    entry_t             rdata_reg;

    entry_t             mem [QUEUE_DEPTH];
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    entry_t             mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;

    logic [CNT_W-1:0]   idx_dec;
    logic [CNT_W-1:0]   idx_inc;
    entry_t             new_entry;
    rsp_t               res_init;
    rsp_t               rsp_next;

    assign idx_dec = idx_reg - CNT_W'(1);
    assign idx_inc = idx_reg + CNT_W'(1);

    assign new_entry.id      = req_reg.patient_id;
    assign new_entry.urgent  = req_reg.urgent;
    assign new_entry.cls     = req_reg.room_class;
    assign new_entry.payload = req_reg.payload_tag;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        res_init        = '0;
        res_init.status = ST_NONE;
        if (req.opcode == OP_ENQ && count_reg == CNT_W'(QUEUE_DEPTH))
        begin
            res_init.status = ST_FULL;
        end
    end

    always_comb
    begin
        rsp_next             = res_reg;
        rsp_next.queue_empty = (count_reg == '0);
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg[IDX_W-1:0];
        mem_wdata = rdata_reg;
        mem_raddr = idx_reg[IDX_W-1:0];
        unique case (state_reg)
            S_INS_CHK:
            begin
                mem_raddr = idx_dec[IDX_W-1:0];
                if (idx_reg == pos_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pos_reg[IDX_W-1:0];
                    mem_wdata = new_entry;
                end
            end
            S_INS_WR:
            begin
                mem_we = 1'b1;
            end
            S_DEL_CHK:
            begin
                mem_raddr = idx_inc[IDX_W-1:0];
            end
            S_DEL_WR:
            begin
                mem_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
            idx_reg       <= '0;
            pos_reg       <= '0;
            req_reg       <= '0;
            res_reg       <= '0;
            rsp_reg       <= '0;
        end
        else
        begin
            if (state_reg == S_FINISH && (!rsp_valid_reg || !rsp_stall))
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        req_reg <= req;
                        res_reg <= res_init;
                        idx_reg <= '0;
                        priority if (req.opcode == OP_ENQ)
                        begin
                            if (count_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                state_reg <= S_FINISH;
                            end
                            else if (req.urgent)
                            begin
                                state_reg <= S_SCAN_RD;
                            end
                            else
                            begin
                                pos_reg   <= count_reg;
                                idx_reg   <= count_reg;
                                state_reg <= S_INS_CHK;
                            end
                        end
                        else if (req.opcode == OP_TAKE || req.opcode == OP_REMOVE)
                        begin
                            state_reg <= S_SCAN_RD;
                        end
                        else
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                end
                S_SCAN_RD:
                begin
                    if (idx_reg == count_reg)
                    begin
                        if (req_reg.opcode == OP_ENQ)
                        begin
                            pos_reg   <= count_reg;
                            state_reg <= S_INS_CHK;
                        end
                        else
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                    else
                    begin
                        state_reg <= S_SCAN_EV;
                    end
                end
                S_SCAN_EV:
                begin
                    priority if (req_reg.opcode == OP_ENQ)
                    begin
                        if (rdata_reg.urgent)
                        begin
                            idx_reg   <= idx_inc;
                            state_reg <= S_SCAN_RD;
                        end
                        else
                        begin
                            pos_reg   <= idx_reg;
                            idx_reg   <= count_reg;
                            state_reg <= S_INS_CHK;
                        end
                    end
                    else if (req_reg.opcode == OP_TAKE
                             && rdata_reg.cls == req_reg.room_class)
                    begin
                        res_reg.status      <= ST_DONE;
                        res_reg.out_id      <= rdata_reg.id;
                        res_reg.out_urgent  <= rdata_reg.urgent;
                        res_reg.out_class   <= rdata_reg.cls;
                        res_reg.out_payload <= rdata_reg.payload;
                        state_reg           <= S_DEL_CHK;
                    end
                    else if (req_reg.opcode == OP_REMOVE
                             && rdata_reg.id == req_reg.patient_id)
                    begin
                        res_reg.status <= ST_DONE;
                        state_reg      <= S_DEL_CHK;
                    end
                    else
                    begin
                        idx_reg   <= idx_inc;
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_INS_CHK:
                begin
                    if (idx_reg == pos_reg)
                    begin
                        count_reg      <= count_reg + CNT_W'(1);
                        res_reg.status <= ST_DONE;
                        state_reg      <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_INS_WR;
                    end
                end
                S_INS_WR:
                begin
                    idx_reg   <= idx_dec;
                    state_reg <= S_INS_CHK;
                end
                S_DEL_CHK:
                begin
                    if (idx_inc >= count_reg)
                    begin
                        count_reg <= count_reg - CNT_W'(1);
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_DEL_WR;
                    end
                end
                S_DEL_WR:
                begin
                    idx_reg   <= idx_inc;
                    state_reg <= S_DEL_CHK;
                end
                S_FINISH:
                begin
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        rsp_reg   <= rsp_next;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/tlpq_check.sv @@
// ----------------------------------------------------------------------------
// tlpq_check: port-level checks of the two-level priority queue
// Watches the request and response channels of the top level and is
// attached to it by the bind statement at the end of this file.
// ----------------------------------------------------------------------------
module tlpq_check
    import tlpq_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    // A response beat held back by the receiver stays in place unchanged.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response beat changed while stalled");

    // Every operation leaves the idle state on acceptance, so an accepted beat closes the gate.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted on two consecutive cycles");

    // A response that returns no entry carries all-zero entry fields.
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_DONE |->
            rsp.out_id == 16'd0 && rsp.out_urgent == 1'b0
            && rsp.out_class == 3'd0 && rsp.out_payload == 16'd0)
        else $error("entry fields not cleared on a miss");

    // A full queue can never be reported as empty.
    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_FULL |-> !rsp.queue_empty)
        else $error("full status with empty queue");

endmodule

bind two_level_priority_queue_with_match tlpq_check u_tlpq_check (.*);
